/* hdl/stt_pkg.sv */
// stt_pkg: types, codes and character classes of the source text tokenizer
// no dependencies
`timescale 1ns / 1ps
package stt_pkg;

  localparam int unsigned PosBits = 16;
  localparam int unsigned LenBits = 16;
  localparam int unsigned ValBits = 63;

  localparam logic [PosBits-1:0] PosMax = '1;
  localparam logic [LenBits-1:0] LenMax = '1;
  localparam logic [ValBits-1:0] ValMax = '1;

  localparam logic [4:0] KindIdent   = 5'd0;
  localparam logic [4:0] KindInt     = 5'd1;
  localparam logic [4:0] KindReal    = 5'd2;
  localparam logic [4:0] KindKwBase  = 5'd3;
  localparam logic [4:0] KindOpBase  = 5'd7;
  localparam logic [4:0] KindDblBase = 5'd21;
  localparam logic [4:0] KindEnd     = 5'd29;
  localparam logic [4:0] KindBadChar = 5'd30;
  localparam logic [4:0] KindBadReal = 5'd31;

  typedef enum logic [5:0] {
    ModeIdle    = 6'b000001,
    ModeIdent   = 6'b000010,
    ModeNumber  = 6'b000100,
    ModeOper    = 6'b001000,
    ModeComment = 6'b010000,
    ModeHalted  = 6'b100000
  } mode_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       final_byte;
  } req_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [15:0] token_length;
    logic [62:0] num_value;
    logic        value_overflow;
    logic        last_of_run;
  } tok_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
  endfunction

  // single operator index 0..13, 4'hf when none
  function automatic logic [3:0] single_index(logic [7:0] c);
    logic [3:0] r;
    r = 4'hf;
    unique case (c)
      "+": r = 4'd0;
      "-": r = 4'd1;
      "*": r = 4'd2;
      "/": r = 4'd3;
      "=": r = 4'd4;
      "(": r = 4'd5;
      ")": r = 4'd6;
      ",": r = 4'd7;
      ":": r = 4'd8;
      ";": r = 4'd9;
      "{": r = 4'd10;
      "}": r = 4'd11;
      "<": r = 4'd12;
      ">": r = 4'd13;
      default: r = 4'hf;
    endcase
    return r;
  endfunction

  // double operator index 0..7, 4'hf when none
  function automatic logic [3:0] double_index(logic [7:0] a, logic [7:0] b);
    logic [3:0] r;
    r = 4'hf;
    if (a == "+" && b == "+") r = 4'd0;
    if (a == "-" && b == "-") r = 4'd1;
    if (a == "*" && b == "*") r = 4'd2;
    if (a == "=" && b == "=") r = 4'd3;
    if (a == "<" && b == "=") r = 4'd4;
    if (a == ">" && b == "=") r = 4'd5;
    if (a == "!" && b == "=") r = 4'd6;
    if (a == "-" && b == ">") r = 4'd7;
    return r;
  endfunction

  function automatic logic starts_double(logic [7:0] c);
    return c == "+" || c == "-" || c == "*" || c == "=" || c == "<" || c == ">"
        || c == "!";
  endfunction

endpackage

/* hdl/stt_if.sv */
// stt_if: valid/ready channels for byte requests and tokens
// depends on stt_pkg
`timescale 1ns / 1ps
interface stt_req_if;
  import stt_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface stt_tok_if;
  import stt_pkg::*;
  logic valid;
  logic ready;
  tok_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/source_text_tokenizer.sv */
// source_text_tokenizer: top level, byte request channel in, token channel out
// depends on stt_pkg, stt_if, stt_scan, stt_outq
//
// Usage: one byte of source text per request on req (ch, final_byte). Each
// byte is scanned in the cycle it is accepted; the tokens it completes (zero
// to three) are registered and offered on tok one per cycle while tok is
// ready from the cycle after the byte is accepted, the last one carrying
// last_of_run. A byte that produces at most one token is accepted every
// cycle while tok is ready; a byte that produces more holds the request
// channel until its last token leaves. Bytes with no token pass at full rate.
// A final_byte request flushes the pending token, adds an end token and
// returns the scanner to its start state for the next text.
// Reset clears the scanner to line 1, column 1 and empties the token queue.
// When the receiver stalls, tokens wait in the queue and the next byte is
// accepted only in the cycle the queue drains its last token.
`timescale 1ns / 1ps
module source_text_tokenizer (
  input  logic      clk_i,
  input  logic      rst_ni,
  stt_req_if.sink   req,
  stt_tok_if.source tok
);
  import stt_pkg::*;

  tok_t       scan_tok [3];
  logic [1:0] scan_cnt;
  logic       free, step;

  assign req.ready = free;
  assign step = req.valid && free;

  stt_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .req_i   (req.data),
    .tok_o   (scan_tok),
    .count_o (scan_cnt)
  );

  stt_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .tok_i   (scan_tok),
    .count_i (scan_cnt),
    .ready_i (tok.ready),
    .valid_o (tok.valid),
    .tok_o   (tok.data),
    .free_o  (free)
  );
endmodule

/* hdl/stt_scan.sv */
// stt_scan: scanner state and combinational next-token logic for one byte
// depends on stt_pkg
`timescale 1ns / 1ps
module stt_scan (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  stt_pkg::req_t   req_i,
  output stt_pkg::tok_t   tok_o [3],
  output logic [1:0]      count_o
);
  import stt_pkg::*;

  mode_e            mode_q, mode_d;
  logic [7:0]       held_q, held_d;
  logic [7:0]       word_q [6];
  logic [7:0]       word_d [6];
  logic [LenBits-1:0] run_q, run_d;
  logic [PosBits-1:0] tline_q, tline_d, tcol_q, tcol_d, line_q, line_d, col_q, col_d;
  logic [ValBits-1:0] acc_q, acc_d;
  logic             per_q, per_d;
  logic             sat_q, sat_d;

  logic [7:0]       c;
  logic [3:0]       dv;
  logic [66:0]      acc_x10;
  logic [3:0]       sidx, didx;
  logic [1:0]       n;
  tok_t             t [3];

  function automatic logic [4:0] ident_kind(logic [LenBits-1:0] len, logic [7:0] w [6]);
    logic [4:0] k;
    k = KindIdent;
    if (len == LenBits'(2) && w[0] == "i" && w[1] == "f") k = KindKwBase;
    else if (len == LenBits'(4) && w[0] == "e" && w[1] == "l" && w[2] == "s"
             && w[3] == "e") k = KindKwBase + 5'd1;
    else if (len == LenBits'(4) && w[0] == "f" && w[1] == "u" && w[2] == "n"
             && w[3] == "c") k = KindKwBase + 5'd2;
    else if (len == LenBits'(6) && w[0] == "r" && w[1] == "e" && w[2] == "t"
             && w[3] == "u" && w[4] == "r" && w[5] == "n") k = KindKwBase + 5'd3;
    return k;
  endfunction

  function automatic logic [15:0] clamp_pos(logic [PosBits-1:0] v);
    return (PosBits > 16 && v > PosBits'(16'hffff)) ? 16'hffff : 16'(v);
  endfunction

  function automatic logic [15:0] clamp_len(logic [LenBits-1:0] v);
    return (LenBits > 16 && v > LenBits'(16'hffff)) ? 16'hffff : 16'(v);
  endfunction

  function automatic tok_t mk(logic [4:0] k, logic [PosBits-1:0] l, logic [PosBits-1:0] cl,
                              logic [LenBits-1:0] len, logic [ValBits-1:0] v, logic o);
    tok_t r;
    r.kind = k;
    r.start_line = clamp_pos(l);
    r.start_column = clamp_pos(cl);
    r.token_length = clamp_len(len);
    r.num_value = v;
    r.value_overflow = o;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  assign c = (req_i.ch == 8'd13) ? 8'h20 : req_i.ch;
  assign dv = 4'(c - 8'h30);
  assign acc_x10 = {4'd0, acc_q} * 67'd10 + 67'(dv);
  assign sidx = single_index(c);
  assign didx = double_index(held_q, c);

  always_comb begin
    mode_d = mode_q;
    held_d = held_q;
    word_d = word_q;
    run_d = run_q;
    tline_d = tline_q;
    tcol_d = tcol_q;
    acc_d = acc_q;
    per_d = per_q;
    sat_d = sat_q;
    n = 2'd0;
    for (int i = 0; i < 3; i++) t[i] = mk(KindEnd, line_q, col_q, '0, '0, 1'b0);

    // fresh-start flag: start a new token from c after the mode handling
    begin
      logic fresh;
      fresh = 1'b0;
      unique case (mode_q)
        ModeHalted: ;
        ModeComment: if (c == 8'h0a) mode_d = ModeIdle;
        ModeIdent: begin
          if (is_alpha(c) || is_digit(c) || c == "_") begin
            for (int i = 0; i < 6; i++) if (run_q == LenBits'(i)) word_d[i] = c;
            if (run_q != LenMax) run_d = run_q + 1'b1;
          end else begin
            t[n] = mk(ident_kind(run_q, word_q), tline_q, tcol_q, run_q, '0, 1'b0);
            n = n + 2'd1;
            fresh = 1'b1;
          end
        end
        ModeNumber: begin
          if (is_digit(c)) begin
            if (sat_q || acc_x10 > {4'd0, ValMax}) begin
              acc_d = ValMax;
              sat_d = 1'b1;
            end else begin
              acc_d = acc_x10[ValBits-1:0];
            end
            if (run_q != LenMax) run_d = run_q + 1'b1;
          end else if (c == ".") begin
            if (run_q != LenMax) run_d = run_q + 1'b1;
            per_d = 1'b1;
            if (per_q) begin
              t[n] = mk(KindBadReal, tline_q, tcol_q, run_d, '0, 1'b0);
              n = n + 2'd1;
              mode_d = ModeHalted;
            end
          end else begin
            if (!per_q) t[n] = mk(KindInt, tline_q, tcol_q, run_q, acc_q, sat_q);
            else t[n] = mk(KindReal, tline_q, tcol_q, run_q, '0, 1'b0);
            n = n + 2'd1;
            fresh = 1'b1;
          end
        end
        ModeOper: begin
          if (didx != 4'hf) begin
            t[n] = mk(KindDblBase + 5'(didx), tline_q, tcol_q, LenBits'(2), '0, 1'b0);
            n = n + 2'd1;
            mode_d = ModeIdle;
          end else if (held_q == "/" && c == "/") begin
            mode_d = ModeComment;
          end else if (single_index(held_q) != 4'hf) begin
            t[n] = mk(KindOpBase + 5'(single_index(held_q)), tline_q, tcol_q,
                      LenBits'(1), '0, 1'b0);
            n = n + 2'd1;
            fresh = 1'b1;
          end else begin
            t[n] = mk(KindBadChar, tline_q, tcol_q, LenBits'(1), '0, 1'b0);
            n = n + 2'd1;
            mode_d = ModeHalted;
          end
        end
        default: fresh = 1'b1;
      endcase

      if (fresh) begin
        mode_d = ModeIdle;
        if (c == 8'd0) begin
          mode_d = ModeHalted;
        end else if (!is_space(c)) begin
          tline_d = line_q;
          tcol_d = col_q;
          if (is_alpha(c)) begin
            mode_d = ModeIdent;
            run_d = LenBits'(1);
            word_d[0] = c;
          end else if (is_digit(c)) begin
            mode_d = ModeNumber;
            run_d = LenBits'(1);
            acc_d = ValBits'(dv);
            per_d = 1'b0;
            sat_d = 1'b0;
          end else if (c == "/" || starts_double(c)) begin
            mode_d = ModeOper;
            held_d = c;
          end else if (sidx != 4'hf) begin
            t[n] = mk(KindOpBase + 5'(sidx), line_q, col_q, LenBits'(1), '0, 1'b0);
            n = n + 2'd1;
          end else begin
            t[n] = mk(KindBadChar, line_q, col_q, LenBits'(1), '0, 1'b0);
            n = n + 2'd1;
            mode_d = ModeHalted;
          end
        end
      end
    end

    if (c == 8'h0a) begin
      line_d = (line_q != PosMax) ? line_q + 1'b1 : line_q;
      col_d = PosBits'(1);
    end else begin
      line_d = line_q;
      col_d = (col_q != PosMax) ? col_q + 1'b1 : col_q;
    end

    if (req_i.final_byte) begin
      unique case (mode_d)
        ModeIdent: begin
          t[n] = mk(ident_kind(run_d, word_d), tline_d, tcol_d, run_d, '0, 1'b0);
          n = n + 2'd1;
        end
        ModeNumber: begin
          if (!per_d) t[n] = mk(KindInt, tline_d, tcol_d, run_d, acc_d, sat_d);
          else t[n] = mk(KindReal, tline_d, tcol_d, run_d, '0, 1'b0);
          n = n + 2'd1;
        end
        ModeOper: begin
          if (single_index(held_d) != 4'hf)
            t[n] = mk(KindOpBase + 5'(single_index(held_d)), tline_d, tcol_d,
                      LenBits'(1), '0, 1'b0);
          else t[n] = mk(KindBadChar, tline_d, tcol_d, LenBits'(1), '0, 1'b0);
          n = n + 2'd1;
        end
        default: ;
      endcase
      t[n] = mk(KindEnd, line_d, col_d, '0, '0, 1'b0);
      n = n + 2'd1;
    end
    if (n != 2'd0) t[n - 2'd1].last_of_run = 1'b1;
  end

  assign tok_o = t;
  assign count_o = n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      held_q <= '0;
      run_q <= '0;
      tline_q <= PosBits'(1);
      tcol_q <= PosBits'(1);
      line_q <= PosBits'(1);
      col_q <= PosBits'(1);
      acc_q <= '0;
      per_q <= 1'b0;
      sat_q <= 1'b0;
    end else if (step_i) begin
      if (req_i.final_byte) begin
        mode_q <= ModeIdle;
        held_q <= '0;
        run_q <= '0;
        tline_q <= PosBits'(1);
        tcol_q <= PosBits'(1);
        line_q <= PosBits'(1);
        col_q <= PosBits'(1);
        acc_q <= '0;
        per_q <= 1'b0;
        sat_q <= 1'b0;
      end else begin
        mode_q <= mode_d;
        held_q <= held_d;
        run_q <= run_d;
        tline_q <= tline_d;
        tcol_q <= tcol_d;
        line_q <= line_d;
        col_q <= col_d;
        acc_q <= acc_d;
        per_q <= per_d;
        sat_q <= sat_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) word_q <= word_d;
  end

  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_q |-> acc_q == ValMax) else $error("saturated accumulator below max");
  a_col_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q != '0 && line_q != '0) else $error("position counter at zero");
  a_fin_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && req_i.final_byte |-> count_o != 2'd0) else $error("final byte without end");
endmodule

/* hdl/stt_outq.sv */
// stt_outq: holds up to three tokens of one byte and hands them out in order
// depends on stt_pkg
`timescale 1ns / 1ps
module stt_outq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  stt_pkg::tok_t tok_i [3],
  input  logic [1:0]    count_i,
  input  logic          ready_i,
  output logic          valid_o,
  output stt_pkg::tok_t tok_o,
  output logic          free_o
);
  import stt_pkg::*;

  tok_t       buf_q [3];
  logic [1:0] rd_q, cnt_q;
  logic       pop;

  assign valid_o = cnt_q != 2'd0;
  assign tok_o = buf_q[rd_q];
  assign pop = valid_o && ready_i;
  // free when empty or the last entry is leaving now
  assign free_o = (cnt_q == 2'd0) || (pop && cnt_q == rd_q + 2'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0;
      cnt_q <= '0;
    end else if (load_i) begin
      rd_q <= '0;
      cnt_q <= count_i;
    end else if (pop) begin
      if (cnt_q == rd_q + 2'd1) begin
        rd_q <= '0;
        cnt_q <= '0;
      end else begin
        rd_q <= rd_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) buf_q <= tok_i;
  end

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o) else $error("load into busy queue");
  a_rd_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> rd_q < cnt_q) else $error("read pointer past count");
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && cnt_q == rd_q + 2'd1 |-> tok_o.last_of_run) else $error("last flag missing");
endmodule

/* tb/source_text_tokenizer_tb.sv */
// source_text_tokenizer_tb: randomized streaming check of the tokenizer against a
// behavioral scanner model; depends on stt_pkg, stt_if and the source_text_tokenizer rtl
`timescale 1ns / 1ps
module source_text_tokenizer_tb;
  import stt_pkg::*;

  typedef enum logic [2:0] {
    ScIdle, ScIdent, ScNumber, ScOper, ScComment, ScHalted
  } scan_e;

  logic clk_i;
  logic rst_ni;
  stt_req_if req ();
  stt_tok_if tok ();

  source_text_tokenizer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req.sink),
    .tok    (tok.source)
  );

  req_t pending_bytes[$];
  tok_t expected_tokens[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit stimulus_done;
  bit in_taken;
  int unsigned hold_off;
  bit long_stall_done;
  int unsigned burst_left;
  int unsigned gap_left;

  // scanner state
  scan_e sc_mode;
  logic [7:0] sc_held;
  logic [7:0] sc_word[6];
  logic [15:0] sc_len, sc_tline, sc_tcol, sc_line, sc_col;
  logic [62:0] sc_acc;
  logic [1:0] sc_periods;
  logic sc_sat;
  tok_t sc_out[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int single_of(logic [7:0] c);
    string ops;
    ops = "+-*/=(),:;{}<>";
    for (int i = 0; i < 14; i++) if (ops[i] == c) return i;
    return -1;
  endfunction

  function automatic int double_of(logic [7:0] a, logic [7:0] b);
    string fa, fb;
    fa = "+-*=<>!-";
    fb = "+-*====>";
    for (int i = 0; i < 8; i++) if (fa[i] == a && fb[i] == b) return i;
    return -1;
  endfunction

  function automatic bit letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit blank(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit opens_double(logic [7:0] c);
    string fa;
    fa = "+-*=<>!";
    for (int i = 0; i < 7; i++) if (fa[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  task automatic scanner_clear();
    sc_mode = ScIdle;
    sc_held = '0;
    for (int i = 0; i < 6; i++) sc_word[i] = '0;
    sc_len = '0;
    sc_tline = 16'd1;
    sc_tcol = 16'd1;
    sc_line = 16'd1;
    sc_col = 16'd1;
    sc_acc = '0;
    sc_periods = '0;
    sc_sat = 1'b0;
  endtask

  function automatic void push_token(logic [4:0] k, logic [15:0] ln, logic [15:0] cl,
                                     logic [15:0] len, logic [62:0] v, logic ovf);
    tok_t t;
    if (sc_out.size() >= 3) return;
    t = '{kind: k, start_line: ln, start_column: cl, token_length: len,
          num_value: v, value_overflow: ovf, last_of_run: 1'b0};
    sc_out.push_back(t);
  endfunction

  task automatic start_token(logic [7:0] c);
    int s;
    sc_mode = ScIdle;
    if (c == 8'd0) begin
      sc_mode = ScHalted;
      return;
    end
    if (blank(c)) return;
    sc_tline = sc_line;
    sc_tcol = sc_col;
    s = single_of(c);
    if (letter(c)) begin
      sc_mode = ScIdent;
      sc_len = 16'd1;
      sc_word[0] = c;
    end else if (digit(c)) begin
      sc_mode = ScNumber;
      sc_len = 16'd1;
      sc_acc = 63'(c - "0");
      sc_periods = '0;
      sc_sat = 1'b0;
    end else if (c == "/" || opens_double(c)) begin
      sc_mode = ScOper;
      sc_held = c;
    end else if (s >= 0) begin
      push_token(KindOpBase + 5'(s), sc_tline, sc_tcol, 16'd1, '0, 1'b0);
    end else begin
      push_token(KindBadChar, sc_tline, sc_tcol, 16'd1, '0, 1'b0);
      sc_mode = ScHalted;
    end
  endtask

  task automatic emit_word();
    logic [4:0] k;
    string w;
    k = KindIdent;
    w = "";
    for (int i = 0; i < 6 && i < sc_len; i++) w = {w, string'(sc_word[i])};
    if (sc_len == 2 && w == "if") k = KindKwBase;
    if (sc_len == 4 && w == "else") k = KindKwBase + 5'd1;
    if (sc_len == 4 && w == "func") k = KindKwBase + 5'd2;
    if (sc_len == 6 && w == "return") k = KindKwBase + 5'd3;
    push_token(k, sc_tline, sc_tcol, sc_len, '0, 1'b0);
  endtask

  task automatic emit_number();
    if (sc_periods == 0) push_token(KindInt, sc_tline, sc_tcol, sc_len, sc_acc, sc_sat);
    else push_token(KindReal, sc_tline, sc_tcol, sc_len, '0, 1'b0);
  endtask

  function automatic bit emit_held();
    int s;
    s = single_of(sc_held);
    if (s < 0) begin
      push_token(KindBadChar, sc_tline, sc_tcol, 16'd1, '0, 1'b0);
      return 1'b0;
    end
    push_token(KindOpBase + 5'(s), sc_tline, sc_tcol, 16'd1, '0, 1'b0);
    return 1'b1;
  endfunction

  task automatic tokenize_byte(req_t r);
    logic [7:0] c;
    logic [62:0] dv;
    int d;
    c = (r.ch == 8'd13) ? " " : r.ch;
    sc_out.delete();
    case (sc_mode)
      ScHalted: ;
      ScComment: if (c == "\n") sc_mode = ScIdle;
      ScIdent: begin
        if (letter(c) || digit(c) || c == "_") begin
          if (sc_len < 6) sc_word[sc_len] = c;
          if (sc_len != LenMax) sc_len++;
        end else begin
          emit_word();
          start_token(c);
        end
      end
      ScNumber: begin
        if (digit(c)) begin
          dv = 63'(c - "0");
          if (sc_sat || sc_acc > (ValMax - dv) / 10) begin
            sc_acc = ValMax;
            sc_sat = 1'b1;
          end else begin
            sc_acc = sc_acc * 10 + dv;
          end
          if (sc_len != LenMax) sc_len++;
        end else if (c == ".") begin
          if (sc_len != LenMax) sc_len++;
          if (sc_periods < 3) sc_periods++;
          if (sc_periods >= 2) begin
            push_token(KindBadReal, sc_tline, sc_tcol, sc_len, '0, 1'b0);
            sc_mode = ScHalted;
          end
        end else begin
          emit_number();
          start_token(c);
        end
      end
      ScOper: begin
        d = double_of(sc_held, c);
        if (d >= 0) begin
          push_token(KindDblBase + 5'(d), sc_tline, sc_tcol, 16'd2, '0, 1'b0);
          sc_mode = ScIdle;
        end else if (sc_held == "/" && c == "/") begin
          sc_mode = ScComment;
        end else if (emit_held()) begin
          start_token(c);
        end else begin
          sc_mode = ScHalted;
        end
      end
      default: start_token(c);
    endcase
    if (c == "\n") begin
      if (sc_line != PosMax) sc_line++;
      sc_col = 16'd1;
    end else if (sc_col != PosMax) begin
      sc_col++;
    end
    if (r.final_byte) begin
      if (sc_mode == ScIdent) emit_word();
      else if (sc_mode == ScNumber) emit_number();
      else if (sc_mode == ScOper) void'(emit_held());
      push_token(KindEnd, sc_line, sc_col, '0, '0, 1'b0);
      scanner_clear();
    end
    if (sc_out.size() > 0) sc_out[sc_out.size() - 1].last_of_run = 1'b1;
    foreach (sc_out[i]) expected_tokens.push_back(sc_out[i]);
  endtask

  task automatic add_text(string s, bit close_it);
    req_t r;
    for (int i = 0; i < s.len(); i++) begin
      r.ch = s[i];
      r.final_byte = close_it && (i == s.len() - 1);
      pending_bytes.push_back(r);
    end
  endtask

  function automatic logic [7:0] pick_char();
    string pool;
    int sel;
    pool = "abcxyzif_else funcreturn0123456789.+-*/=(),:;{}<>!\n\r\t  ";
    sel = $urandom_range(0, 99);
    if (sel < 4) return 8'($urandom_range(0, 255));
    if (sel < 5) return 8'd0;
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  // stimulus
  initial begin
    string words[$];
    string s;
    int n;
    words = '{"if", "else", "func", "return", "iff", "els", "returns", "x_1", "A9",
              "++", "--", "**", "==", "<=", ">=", "!=", "->", "//c\n", "12", "3.5",
              "9223372036854775807", "99999999999999999999", "+", "-", "*", "/", "=",
              "(", ")", ",", ":", ";", "{", "}", "<", ">", "\n", " ", "\r", "\t",
              "Zed", "_a"};
    add_text("func f(a,b){return a<=b;}", 1'b1);
    add_text("x1 == 18446744073709551616 -> y\r\n// note\nz", 1'b1);
    add_text("1.2.3", 1'b1);
    add_text("a ! b", 1'b1);
    add_text("!", 1'b1);
    add_text("_", 1'b1);
    add_text("q .", 1'b1);
    add_text("ab", 1'b0);
    pending_bytes.push_back('{ch: 8'd0, final_byte: 1'b0});
    add_text("zz", 1'b1);
    add_text("\xff\x80", 1'b1);
    while (pending_bytes.size() < 300) begin
      if ($urandom_range(0, 3) != 0) begin
        s = "";
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
          s = {s, words[$urandom_range(0, words.size() - 1)]};
          if ($urandom_range(0, 1)) s = {s, " "};
        end
        add_text(s, 1'b1);
      end else begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
          pending_bytes.push_back('{ch: pick_char(), final_byte: i == n - 1});
      end
    end
    stimulus_done = 1'b1;
  end

  // driver
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req.valid <= 1'b0;
      req.data <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (req.valid && !in_taken) begin
      // hold the current byte
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      req.valid <= 1'b0;
    end else if (pending_bytes.size() > 0) begin
      req.valid <= 1'b1;
      req.data <= pending_bytes[0];
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      req.valid <= 1'b0;
    end
  end

  // receiver stall pattern, with one long hold-off
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok.ready <= 1'b0;
      hold_off <= 0;
      long_stall_done <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      tok.ready <= 1'b0;
    end else if (!long_stall_done && cycle_count > 400) begin
      hold_off <= 200;
      long_stall_done <= 1'b1;
      tok.ready <= 1'b0;
    end else begin
      tok.ready <= (cycle_count % 64 < 32) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // monitor and predictor
  always @(posedge clk_i) begin
    tok_t want;
    in_taken = req.valid && req.ready;
    if (!rst_ni) begin
      scanner_clear();
    end else begin
      cycle_count <= cycle_count + 1;
      if (tok.valid && tok.ready) begin
        if (expected_tokens.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10) $display("unexpected token %p", tok.data);
        end else begin
          want = expected_tokens.pop_front();
          if (tok.data !== want) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10)
              $display("token mismatch: expected %p actual %p", want, tok.data);
          end
        end
      end
      if (in_taken) begin
        tokenize_byte(req.data);
        void'(pending_bytes.pop_front());
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait (stimulus_done);
    while ((pending_bytes.size() > 0 || req.valid || expected_tokens.size() > 0)
           && cycle_count < 200000)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (cycle_count >= 200000 || mismatch_count != 0 || expected_tokens.size() != 0) begin
      $display("source_text_tokenizer: mismatch");
    end else begin
      $display("source_text_tokenizer: match");
    end
    $finish;
  end

endmodule
